// File: src/kca_pkg.sv
// Keystroke code assembler: shared types, codes and defaults.
// Used by kca_ctrl, kca_datapath and keystroke_code_assembler_top.
package kca_pkg;

  localparam int DEF_MAX_LEN    = 32;
  localparam int DEF_PREFIX_MAX = 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_GAP_MS       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEN      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PREFIX_LEN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PREFIX_CHARS = 3'd4;

  localparam logic [15:0] RST_GAP_MS     = 16'd50;
  localparam logic [5:0]  RST_MIN_LEN    = 6'd1;
  localparam logic [5:0]  RST_MAX_LEN    = 6'd32;
  localparam logic [3:0]  RST_PREFIX_LEN = 4'd0;

  localparam logic [7:0] KEY_ENTER = 8'd13;
  localparam logic [7:0] KEY_BACK  = 8'd8;
  localparam logic [7:0] CHR_0     = 8'h30;
  localparam logic [7:0] CHR_9     = 8'h39;
  localparam logic [7:0] CHR_A     = 8'h41;
  localparam logic [7:0] CHR_Z     = 8'h5A;
  localparam logic [7:0] CASE_OFS  = 8'd32;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_CHAR,
    KIND_ENTER,
    KIND_BACK
  } key_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GAP,
    ST_KEY,
    ST_FETCH,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic take;
    logic append;
    logic back;
    logic clear;
    logic fetch;
    logic emit;
  } kca_cmd_t;

  typedef struct packed {
    logic      gap_hit;
    logic      code_ok;
    key_kind_t kind;
    logic      out_free;
    logic      emit_last;
  } kca_sts_t;

endpackage

// File: src/keystroke_code_assembler_top.sv
// Keystroke code assembler, top level. Instantiates kca_ctrl and
// kca_datapath; parameters default from kca_pkg.
//
// Usage:
//   Key channel: key_valid / key_stall carry key_code, shift_held, time_ms.
//   Code channel: code_valid / code_stall carry code_char, last_char and
//   code_length, one request per character, first character first.
//   Config port: cfg_write with cfg_index 0..4 (gap_ms, min_len, max_len,
//   prefix_len, prefix_chars) and cfg_data; write only while idle.
// Timing:
//   A key that closes no code passes the gap check and key handling
//   before the next key can be taken. A key that closes a code takes
//   one fetch from the character memory, then one character per cycle,
//   unless the output stalls, from its registered read port into the
//   output register.
// Reset (rst, synchronous): config returns to its defaults, the buffer is
//   emptied and the output register is empty; buffer contents are not
//   cleared and are never used before being written.
// Stall: a stalled code request holds; emission pauses until it is taken.
//   key_stall is high whenever the block is not waiting for a key.
module keystroke_code_assembler_top #(
  parameter int MAX_LEN    = kca_pkg::DEF_MAX_LEN,
  parameter int PREFIX_MAX = kca_pkg::DEF_PREFIX_MAX
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [kca_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kca_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           key_valid,
  output logic                           key_stall,
  input  logic [7:0]                     key_code,
  input  logic                           shift_held,
  input  logic [31:0]                    time_ms,
  output logic                           code_valid,
  input  logic                           code_stall,
  output logic [6:0]                     code_char,
  output logic                           last_char,
  output logic [5:0]                     code_length
);

  kca_pkg::kca_cmd_t cmd;
  kca_pkg::kca_sts_t sts;

  kca_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .key_valid (key_valid),
    .key_stall (key_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  kca_datapath #(
    .MAX_LEN    (MAX_LEN),
    .PREFIX_MAX (PREFIX_MAX)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .key_code    (key_code),
    .shift_held  (shift_held),
    .time_ms     (time_ms),
    .code_valid  (code_valid),
    .code_stall  (code_stall),
    .code_char   (code_char),
    .last_char   (last_char),
    .code_length (code_length),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule

// File: src/kca_ctrl.sv
// Keystroke code assembler controller: sequences gap check, key handling
// and code emission. Uses kca_pkg types; drives kca_datapath by commands.
module kca_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              key_valid,
  output logic              key_stall,
  input  kca_pkg::kca_sts_t sts,
  output kca_pkg::kca_cmd_t cmd
);

  kca_pkg::state_t state, state_next;
  logic ret_key, ret_key_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= kca_pkg::ST_IDLE;
      ret_key <= 1'b0;
    end else begin
      state   <= state_next;
      ret_key <= ret_key_next;
    end
  end

  always_comb begin
    state_next   = state;
    ret_key_next = ret_key;
    cmd          = '0;
    key_stall    = (state != kca_pkg::ST_IDLE);
    case (state)
      kca_pkg::ST_IDLE: begin
        if (key_valid) begin
          cmd.take   = 1'b1;
          state_next = kca_pkg::ST_GAP;
        end
      end
      kca_pkg::ST_GAP: begin
        state_next = kca_pkg::ST_KEY;
        if (sts.gap_hit) begin
          if (sts.code_ok) begin
            ret_key_next = 1'b1;
            state_next   = kca_pkg::ST_FETCH;
          end else begin
            cmd.clear = 1'b1;
          end
        end
      end
      kca_pkg::ST_KEY: begin
        state_next = kca_pkg::ST_IDLE;
        case (sts.kind)
          kca_pkg::KIND_CHAR:  cmd.append = 1'b1;
          kca_pkg::KIND_BACK:  cmd.back = 1'b1;
          kca_pkg::KIND_ENTER: begin
            if (sts.code_ok) begin
              ret_key_next = 1'b0;
              state_next   = kca_pkg::ST_FETCH;
            end else begin
              cmd.clear = 1'b1;
            end
          end
          default: ;
        endcase
      end
      kca_pkg::ST_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = kca_pkg::ST_EMIT;
      end
      kca_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.emit_last) begin
            cmd.clear  = 1'b1;
            state_next = ret_key ? kca_pkg::ST_KEY : kca_pkg::ST_IDLE;
          end
        end
      end
      default: state_next = kca_pkg::ST_IDLE;
    endcase
  end

  // emission always starts with a fetch
  a_emit_after_fetch: assert property (@(posedge clk) disable iff (rst)
    state == kca_pkg::ST_EMIT |->
      $past(state) == kca_pkg::ST_FETCH || $past(state) == kca_pkg::ST_EMIT)
    else $error("emit state entered without fetch");

  // emission returns to key handling only when a gap closed the code
  a_ret_path: assert property (@(posedge clk) disable iff (rst)
    state == kca_pkg::ST_GAP && sts.gap_hit && sts.code_ok |=> ret_key)
    else $error("return path lost after gap close");

endmodule

// File: src/kca_datapath.sv
// Keystroke code assembler datapath: config registers, character buffer,
// prefix copy, validity check and output register. Uses kca_pkg.
module kca_datapath #(
  parameter int MAX_LEN    = kca_pkg::DEF_MAX_LEN,
  parameter int PREFIX_MAX = kca_pkg::DEF_PREFIX_MAX
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [kca_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kca_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [7:0]                     key_code,
  input  logic                           shift_held,
  input  logic [31:0]                    time_ms,
  output logic                           code_valid,
  input  logic                           code_stall,
  output logic [6:0]                     code_char,
  output logic                           last_char,
  output logic [5:0]                     code_length,
  input  kca_pkg::kca_cmd_t              cmd,
  output kca_pkg::kca_sts_t              sts
);

  localparam int CW   = $clog2(MAX_LEN + 1);
  localparam int AW   = $clog2(MAX_LEN);
  localparam int CMPW = 8;

  logic [15:0] gap_ms;
  logic [5:0]  min_len;
  logic [5:0]  max_len;
  logic [3:0]  prefix_len;
  logic [63:0] prefix_chars;

  logic [6:0]    mem [MAX_LEN];
  logic [6:0]    head [PREFIX_MAX];
  logic [6:0]    rd_data;
  logic [AW-1:0] emit_idx;
  logic [CW-1:0] count;
  logic          overflowed;
  logic [31:0]   last_time;
  logic          gap_hit;
  logic [7:0]    key;
  logic          shift;

  logic [6:0]      ch;
  logic [3:0]      plen;
  logic            prefix_ok;
  logic            code_ok;
  logic [CMPW-1:0] count_x;
  logic [31:0]     gap;
  logic            has_room;
  logic [AW-1:0]   rd_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_ms       <= kca_pkg::RST_GAP_MS;
      min_len      <= kca_pkg::RST_MIN_LEN;
      max_len      <= kca_pkg::RST_MAX_LEN;
      prefix_len   <= kca_pkg::RST_PREFIX_LEN;
      prefix_chars <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        kca_pkg::CFG_GAP_MS:       gap_ms <= cfg_data[15:0];
        kca_pkg::CFG_MIN_LEN:      min_len <= cfg_data[5:0];
        kca_pkg::CFG_MAX_LEN:      max_len <= cfg_data[5:0];
        kca_pkg::CFG_PREFIX_LEN:   prefix_len <= cfg_data[3:0];
        kca_pkg::CFG_PREFIX_CHARS: prefix_chars <= cfg_data;
        default: ;
      endcase
    end
  end

  assign gap      = time_ms - last_time;
  assign count_x  = CMPW'(count);
  assign has_room = (count < CW'(MAX_LEN));

  always_comb begin
    if (key >= kca_pkg::CHR_A && key <= kca_pkg::CHR_Z && !shift) begin
      ch = 7'(key + kca_pkg::CASE_OFS);
    end else begin
      ch = key[6:0];
    end
  end

  always_comb begin
    plen = (prefix_len > 4'(PREFIX_MAX)) ? 4'(PREFIX_MAX) : prefix_len;
    prefix_ok = (count_x >= CMPW'(plen));
    for (int i = 0; i < PREFIX_MAX; i++) begin
      if (4'(i) < plen && {1'b0, head[i]} != prefix_chars[8*i +: 8]) begin
        prefix_ok = 1'b0;
      end
    end
    code_ok = (count != '0) && !overflowed && prefix_ok &&
              (count_x >= CMPW'(min_len)) && (count_x <= CMPW'(max_len));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      overflowed <= 1'b0;
      last_time  <= '0;
      gap_hit    <= 1'b0;
    end else begin
      if (cmd.take) begin
        gap_hit   <= (gap > {16'd0, gap_ms}) && (count != '0);
        last_time <= time_ms;
      end
      if (cmd.clear) begin
        count      <= '0;
        overflowed <= 1'b0;
      end else if (cmd.append) begin
        if (has_room) begin
          count <= count + CW'(1);
        end else begin
          overflowed <= 1'b1;
        end
      end else if (cmd.back && count != '0) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      key   <= key_code;
      shift <= shift_held;
    end
    if (cmd.append) begin
      for (int i = 0; i < PREFIX_MAX; i++) begin
        if (count == CW'(i)) begin
          head[i] <= ch;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.append && has_room) begin
      mem[count[AW-1:0]] <= ch;
    end
  end

  assign rd_addr = cmd.fetch ? '0 : emit_idx + AW'(1);

  always_ff @(posedge clk) begin
    if (cmd.fetch || cmd.emit) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      emit_idx <= '0;
    end else if (cmd.emit) begin
      emit_idx <= emit_idx + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      code_valid <= 1'b0;
    end else if (cmd.emit) begin
      code_valid <= 1'b1;
    end else if (!code_stall) begin
      code_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      code_char   <= rd_data;
      last_char   <= sts.emit_last;
      code_length <= 6'(count);
    end
  end

  always_comb begin
    sts.gap_hit   = gap_hit;
    sts.code_ok   = code_ok;
    sts.out_free  = !code_valid || !code_stall;
    sts.emit_last = (CW'(emit_idx) + CW'(1) == count);
    if (key >= kca_pkg::CHR_0 && key <= kca_pkg::CHR_9) begin
      sts.kind = kca_pkg::KIND_CHAR;
    end else if (key >= kca_pkg::CHR_A && key <= kca_pkg::CHR_Z) begin
      sts.kind = kca_pkg::KIND_CHAR;
    end else if (key == kca_pkg::KEY_ENTER) begin
      sts.kind = kca_pkg::KIND_ENTER;
    end else if (key == kca_pkg::KEY_BACK) begin
      sts.kind = kca_pkg::KIND_BACK;
    end else begin
      sts.kind = kca_pkg::KIND_NONE;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_LEN))
    else $error("character count beyond buffer depth");

  a_emit_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !code_valid || !code_stall)
    else $error("output register overwritten while stalled");

  a_close_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.emit && sts.emit_last |=> count == '0 && !overflowed)
    else $error("buffer not cleared after last character");

endmodule
